// ----- hdl/pfs_pkg.sv -----
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared widths and constants of the prime field S-box triple block.
// ----------------------------------------------------------------------------
package pfs_pkg;

   localparam int ELEM_WIDTH = 32;
   localparam int WIDE_WIDTH = 2 * ELEM_WIDTH;

   localparam logic [ELEM_WIDTH-1:0] RESET_MODULUS = ELEM_WIDTH'(64'd4294967291);

   typedef logic [ELEM_WIDTH-1:0] elem_type;
   typedef logic [WIDE_WIDTH-1:0] wide_type;

endpackage

// ----- hdl/pfs_reduce.sv -----
// ----------------------------------------------------------------------------
// pfs_reduce
// Pipelined restoring reduction of a double-width word modulo p, one
// dividend bit retired per stage.
// ----------------------------------------------------------------------------
module pfs_reduce (
   input  logic               clock,
   input  logic               enable,
   input  pfs_pkg::wide_type  value_in,
   input  pfs_pkg::elem_type  modulus,
   output pfs_pkg::elem_type  rem_out
);
   import pfs_pkg::*;

   elem_type rem_ff  [WIDE_WIDTH];
   wide_type bits_ff [WIDE_WIDTH];

   for (genvar i = 0; i < WIDE_WIDTH; i++) begin : g_stage
      elem_type                rem_prev;
      wide_type                bits_prev;
      logic [ELEM_WIDTH:0]     trial;
      logic [ELEM_WIDTH:0]     diff;
      elem_type                rem_in;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign bits_prev = value_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign bits_prev = bits_ff[i-1];
      end

      always_comb begin
         trial = {rem_prev, bits_prev[WIDE_WIDTH-1]};
         diff  = trial - {1'b0, modulus};
         if (trial >= {1'b0, modulus}) begin
            rem_in = diff[ELEM_WIDTH-1:0];
         end else begin
            rem_in = trial[ELEM_WIDTH-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[i]  <= rem_in;
            bits_ff[i] <= {bits_prev[WIDE_WIDTH-2:0], 1'b0};
         end
      end
   end

   assign rem_out = rem_ff[WIDE_WIDTH-1];

endmodule

// ----- hdl/pfs_merge.sv -----
// ----------------------------------------------------------------------------
// pfs_merge
// Combines the reduced lanes into the three outputs and holds the result
// register.
// ----------------------------------------------------------------------------
module pfs_merge (
   input  logic               clock,
   input  logic               enable,
   input  pfs_pkg::elem_type  modulus,
   input  pfs_pkg::elem_type  a_red,
   input  pfs_pkg::elem_type  b_red,
   input  pfs_pkg::elem_type  c_red,
   input  pfs_pkg::elem_type  t_red,
   input  pfs_pkg::elem_type  u_red,
   output pfs_pkg::elem_type  y0_out,
   output pfs_pkg::elem_type  y1_out,
   output pfs_pkg::elem_type  y2_out
);
   import pfs_pkg::*;

   elem_type            y0_ff, y1_ff, y2_ff;
   elem_type            y0_in, y1_in, y2_in;
   logic [ELEM_WIDTH:0] sum1, sum2, diff2;
   elem_type            tc;

   always_comb begin
      sum1 = {1'b0, t_red} + {1'b0, b_red};
      sum2 = {1'b0, t_red} + {1'b0, c_red};
      if (sum2 >= {1'b0, modulus}) begin
         sum2 = sum2 - {1'b0, modulus};
      end
      tc = sum2[ELEM_WIDTH-1:0];
      if (tc >= u_red) begin
         diff2 = {1'b0, tc - u_red};
      end else begin
         diff2 = {1'b0, tc} + {1'b0, modulus} - {1'b0, u_red};
      end
      if (sum1 >= {1'b0, modulus}) begin
         sum1 = sum1 - {1'b0, modulus};
      end
      if (modulus < ELEM_WIDTH'(2)) begin
         y0_in = '0;
         y1_in = '0;
         y2_in = '0;
      end else begin
         y0_in = a_red;
         y1_in = sum1[ELEM_WIDTH-1:0];
         y2_in = diff2[ELEM_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         y0_ff <= y0_in;
         y1_ff <= y1_in;
         y2_ff <= y2_in;
      end
   end

   assign y0_out = y0_ff;
   assign y1_out = y1_ff;
   assign y2_out = y2_ff;

endmodule

// ----- hdl/prime_field_sbox_triple.sv -----
// ----------------------------------------------------------------------------
// prime_field_sbox_triple
// An accepted transaction passes through one product stage, 64 reduction
// stages and one merge stage to its result.
// Throughput: one transaction per cycle, set by the fully pipelined product
// stage and per-bit reduction lanes; the pipeline holds only while a result
// is stalled. Reset clears the valid pipeline and loads the modulus default.
// ----------------------------------------------------------------------------
module prime_field_sbox_triple (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  pfs_pkg::elem_type  csr_modulus,
   input  logic               req_valid,
   output logic               req_stall,
   input  pfs_pkg::elem_type  req_elem0_in,
   input  pfs_pkg::elem_type  req_elem1_in,
   input  pfs_pkg::elem_type  req_elem2_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output pfs_pkg::elem_type  rsp_elem0_out,
   output pfs_pkg::elem_type  rsp_elem1_out,
   output pfs_pkg::elem_type  rsp_elem2_out
);
   import pfs_pkg::*;

   elem_type                  modulus_ff;
   logic                      enable;
   logic                      in_vld_ff;
   logic [WIDE_WIDTH-1:0]     vld_ff;
   logic                      rsp_valid_ff;
   wide_type                  x0_ff, x1_ff, x2_ff, p02_ff, p01_ff;
   elem_type                  a_red, b_red, c_red, t_red, u_red;

   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= RESET_MODULUS;
      end else if (csr_write) begin
         modulus_ff <= csr_modulus;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         in_vld_ff    <= req_valid;
         vld_ff       <= {vld_ff[WIDE_WIDTH-2:0], in_vld_ff};
         rsp_valid_ff <= vld_ff[WIDE_WIDTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x0_ff  <= WIDE_WIDTH'(req_elem0_in);
         x1_ff  <= WIDE_WIDTH'(req_elem1_in);
         x2_ff  <= WIDE_WIDTH'(req_elem2_in);
         p02_ff <= WIDE_WIDTH'(req_elem0_in) * WIDE_WIDTH'(req_elem2_in);
         p01_ff <= WIDE_WIDTH'(req_elem0_in) * WIDE_WIDTH'(req_elem1_in);
      end
   end

   pfs_reduce u_lane_a (.clock(clock), .enable(enable), .value_in(x0_ff),
                        .modulus(modulus_ff), .rem_out(a_red));
   pfs_reduce u_lane_b (.clock(clock), .enable(enable), .value_in(x1_ff),
                        .modulus(modulus_ff), .rem_out(b_red));
   pfs_reduce u_lane_c (.clock(clock), .enable(enable), .value_in(x2_ff),
                        .modulus(modulus_ff), .rem_out(c_red));
   pfs_reduce u_lane_t (.clock(clock), .enable(enable), .value_in(p02_ff),
                        .modulus(modulus_ff), .rem_out(t_red));
   pfs_reduce u_lane_u (.clock(clock), .enable(enable), .value_in(p01_ff),
                        .modulus(modulus_ff), .rem_out(u_red));

   pfs_merge u_merge (
      .clock   (clock),
      .enable  (enable),
      .modulus (modulus_ff),
      .a_red   (a_red),
      .b_red   (b_red),
      .c_red   (c_red),
      .t_red   (t_red),
      .u_red   (u_red),
      .y0_out  (rsp_elem0_out),
      .y1_out  (rsp_elem1_out),
      .y2_out  (rsp_elem2_out)
   );

endmodule

// ----- tb/prime_field_sbox_triple_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_field_sbox_triple_tb
// Drives triples through the prime field S-box block with random gaps and
// stalls and compares every result with a predicted triple of residues. The
// modulus is changed between phases while the block is drained.
// ----------------------------------------------------------------------------
module prime_field_sbox_triple_tb;
   import pfs_pkg::*;

   typedef struct packed {
      elem_type y0;
      elem_type y1;
      elem_type y2;
   } residue_triple_type;

   logic     clock;
   logic     reset;
   logic     csr_write;
   elem_type csr_modulus;
   logic     req_valid;
   logic     req_stall;
   elem_type req_elem0_in;
   elem_type req_elem1_in;
   elem_type req_elem2_in;
   logic     rsp_valid;
   logic     rsp_stall;
   elem_type rsp_elem0_out;
   elem_type rsp_elem1_out;
   elem_type rsp_elem2_out;

   residue_triple_type expected_residues[$];
   elem_type           field_modulus;
   int                 mismatch_count;
   int                 hold_off_cycles;
   bit                 random_stall_on;

   prime_field_sbox_triple i_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_modulus   (csr_modulus),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_elem0_in  (req_elem0_in),
      .req_elem1_in  (req_elem1_in),
      .req_elem2_in  (req_elem2_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_elem0_out (rsp_elem0_out),
      .rsp_elem1_out (rsp_elem1_out),
      .rsp_elem2_out (rsp_elem2_out)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("prime_field_sbox_triple_tb failed");
      $finish;
   end

   function automatic residue_triple_type sbox_residues(elem_type x0, elem_type x1,
                                                        elem_type x2);
      logic [127:0]       p;
      logic [127:0]       a;
      logic [127:0]       b;
      logic [127:0]       c;
      logic [127:0]       t;
      residue_triple_type r;
      p = {96'd0, field_modulus};
      if (field_modulus < 2) begin
         r = '0;
         return r;
      end
      a = {96'd0, x0} % p;
      b = {96'd0, x1} % p;
      c = {96'd0, x2} % p;
      t = (a * c) % p;
      r.y0 = a[ELEM_WIDTH-1:0];
      r.y1 = ELEM_WIDTH'((t + b) % p);
      r.y2 = ELEM_WIDTH'((t + c + p - (a * b) % p) % p);
      return r;
   endfunction

   task automatic send_triple(elem_type x0, elem_type x1, elem_type x2);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_elem0_in <= x0;
      req_elem1_in <= x1;
      req_elem2_in <= x2;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_residues.push_back(sbox_residues(x0, x1, x2));
      @(negedge clock);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      while (expected_residues.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_modulus(elem_type value);
      drain_block();
      csr_write   <= 1'b1;
      csr_modulus <= value;
      field_modulus = value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic elem_type random_element();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return field_modulus;
         3: return field_modulus - 1;
         4: return ELEM_WIDTH'($urandom_range(0, 15));
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      elem_type p;
      p = field_modulus;
      send_triple('0, '0, '0);
      send_triple('1, '1, '1);
      send_triple(p, p, p);
      send_triple(p - 1, p - 1, p - 1);
      send_triple(p + 1, 1, p + 2);
      send_triple(1, 0, 0);
      send_triple(0, 1, 0);
      send_triple(0, 0, 1);
      send_triple(2, 3, 5);
      send_triple(32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA);
   endtask

   task automatic test_random(int count);
      repeat (count) send_triple(random_element(), random_element(), random_element());
   endtask

   task automatic test_degenerate_modulus();
      write_modulus(0);
      test_random(10);
      write_modulus(1);
      test_random(10);
   endtask

   task automatic test_back_pressure();
      hold_off_cycles = 200;
      test_random(120);
   endtask

   initial begin
      reset           = 1'b1;
      csr_write       = 1'b0;
      csr_modulus     = '0;
      req_valid       = 1'b0;
      req_elem0_in    = '0;
      req_elem1_in    = '0;
      req_elem2_in    = '0;
      field_modulus   = RESET_MODULUS;
      mismatch_count  = 0;
      hold_off_cycles = 0;
      random_stall_on = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random(300);
      write_modulus(32'd5);
      test_directed();
      test_random(200);
      write_modulus(32'd2);
      test_random(100);
      test_degenerate_modulus();
      write_modulus('1);
      test_directed();
      test_random(200);
      write_modulus(32'd2147483647);
      test_back_pressure();
      random_stall_on = 1'b0;
      test_random(150);
      random_stall_on = 1'b1;
      write_modulus(32'd4294967291);
      test_random(330);
      drain_block();
      if (mismatch_count == 0) begin
         $display("prime_field_sbox_triple_tb passed");
      end else begin
         $display("prime_field_sbox_triple_tb failed");
      end
      $finish;
   end

   // The receiver stall runs on its own; a long hold-off fills the pipeline.
   initial begin
      int wait_cycles;
      rsp_stall = 1'b1;
      @(negedge clock);
      forever begin
         if (hold_off_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_cycles) @(negedge clock);
            hold_off_cycles = 0;
         end
         wait_cycles = random_stall_on ? $urandom_range(0, 4) : 0;
         if (wait_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      residue_triple_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_residues.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected transaction: %h %h %h",
                        rsp_elem0_out, rsp_elem1_out, rsp_elem2_out);
         end else begin
            exp_r = expected_residues.pop_front();
            if (rsp_elem0_out !== exp_r.y0 || rsp_elem1_out !== exp_r.y1 ||
                rsp_elem2_out !== exp_r.y2) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected %h %h %h, actual %h %h %h",
                           exp_r.y0, exp_r.y1, exp_r.y2,
                           rsp_elem0_out, rsp_elem1_out, rsp_elem2_out);
            end
         end
      end
   end

endmodule
